// ===== src/tbw_pkg.sv =====
package tbw_pkg;

    // Q1.16 unity and the floor under which grit counts as zero
    localparam logic [16:0] Q16_ONE    = 17'd65536;
    localparam logic [16:0] GRIT_FLOOR = 17'd7;

    // 0.35 and 1.3 in Q16
    localparam logic [14:0] K_BEND = 15'd22938;
    localparam logic [16:0] K_ASYM = 17'd85197;

    // 3.5 in Q30, clamp on |x| before the bend term
    localparam logic [31:0] BEND_CLAMP = 32'd3758096384;

    // tanh table build: number of double-angle steps
    localparam int DOUBLINGS = 10;

    // restoring divider: quotient bits and bits resolved per stage
    localparam int DIV_QBITS = 32;
    localparam int DIV_STEP  = 2;

    // configuration register indexes
    localparam logic [0:0] CFG_GRIT_AMOUNT   = 1'b0;
    localparam logic [0:0] CFG_CHARACTER_MIX = 1'b1;

    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

endpackage

// ===== src/tanh_blend_waveshaper.sv =====
// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_stall     i_sample_in, i_envelope_gain
// output    out        o_valid / i_stall     o_sample_out
// config    in         i_cfg_wr_en           i_cfg_index, i_cfg_data
//
// One sample per cycle while the output is not stalled; each result passes
// through the 16-stage restoring divider.
// Reset (synchronous, active low) clears the valid bits and both registers.
// A stalled output holds the whole pipeline; o_stall follows it directly.
// The tanh table is a ROM read at two addresses per cycle, data registered.
module tanh_blend_waveshaper #(
    parameter int SAMPLE_FRAC_BITS = 20,
    parameter int TANH_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [23:0] i_sample_in,
    input  logic [16:0]        i_envelope_gain,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_sample_out,
    input  logic               i_cfg_wr_en,
    input  logic [0:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);
    import tbw_pkg::*;

    localparam int SH     = 30 - SAMPLE_FRAC_BITS;
    localparam int XW     = 24 + SH;
    localparam int AW     = (XW + 4 > 38) ? XW + 4 : 38;
    localparam int IW     = $clog2(TANH_TABLE_DEPTH);
    localparam int DW     = ((XW > 33) ? XW : 33) + 1;
    localparam int PW     = DW + 26;
    localparam int DIV_ST = DIV_QBITS / DIV_STEP;
    localparam int NV     = 14 + DIV_ST;

    typedef logic [63:0] t_pair_tab [0:TANH_TABLE_DEPTH-1];

    typedef struct packed {
        logic signed [23:0]    s;
        logic                  neg;
        logic [32:0]           wet;
        logic                  glow;
        logic                  byp;
        logic [XW-1:0]         xm;
        logic [31:0]           xc;
        logic [19:0]           d16;
        logic [33:0]           sq;
        logic [32:0]           bend;
        logic [AW-1:0]         sarg;
        logic [36:0]           a1;
        logic [AW-1:0]         aarg;
        logic [IW-1:0]         sidx;
        logic [IW-1:0]         aidx;
        logic [29:0]           sfrac;
        logic [29:0]           afrac;
        logic                  ssat;
        logic                  asat;
        logic [31:0]           st0;
        logic [31:0]           at0;
        logic signed [63:0]    sprod;
        logic signed [63:0]    aprod;
        logic signed [31:0]    sym;
        logic signed [31:0]    asym;
        logic signed [50:0]    bprod;
        logic                  bneg;
        logic [47:0]           num;
        logic [19:0]           rem;
        logic [31:0]           quo;
        logic signed [DW-1:0]  diff;
        logic signed [PW-1:0]  mprod;
    } t_pipe;

    // round half away from zero, arithmetic right shift
    function automatic logic signed [79:0] f_rsr(input logic signed [79:0] v,
                                                 input int unsigned n);
        logic [79:0] mag;
        logic [79:0] half;
        half = (n == 0) ? 80'd0 : (80'd1 << (n - 1));
        mag  = v[79] ? 80'(-v) : 80'(v);
        mag  = (mag + half) >> n;
        return v[79] ? -$signed(mag) : $signed(mag);
    endfunction

    // shift-subtract unsigned divide, used only while building the table
    function automatic logic [63:0] f_udiv(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // tanh(8*i/depth) in Q31: cubic seed at 1/1024 scale, then double-angle steps
    function automatic logic [31:0] f_tanh_point(input int unsigned i);
        logic [63:0] den;
        logic [63:0] a;
        logic [63:0] a3;
        logic [63:0] t;
        logic [63:0] d;
        den = 64'(TANH_TABLE_DEPTH) << DOUBLINGS;
        a   = f_udiv((64'(i) << 34) + (den >> 1), den);
        a3  = (((a * a) >> 31) * a) >> 31;
        t   = a - f_udiv(a3, 64'd3);
        for (int k = 0; k < DOUBLINGS; k++) begin
            d = (64'd1 << 31) + ((t * t + (64'd1 << 30)) >> 31);
            t = f_udiv((t << 32) + (d >> 1), d);
            if (t > (64'd1 << 31)) begin
                t = 64'd1 << 31;
            end
        end
        return 32'(t);
    endfunction

    function automatic t_pair_tab f_build();
        t_pair_tab tab;
        for (int i = 0; i < TANH_TABLE_DEPTH; i++) begin
            tab[i] = {f_tanh_point(i + 1), f_tanh_point(i)};
        end
        return tab;
    endfunction

    localparam t_pair_tab TANH_PAIR = f_build();
    localparam logic [31:0] TANH_LAST_HALF =
        32'((33'(f_tanh_point(TANH_TABLE_DEPTH)) + 33'd1) >> 1);
    localparam logic [IW:0] DEPTH_K = (IW + 1)'(TANH_TABLE_DEPTH);

    logic [16:0]  r_grit;
    logic [16:0]  r_char;
    logic [NV-1:0] r_vld;
    logic          adv;
    logic          in_xfer;

    t_pipe r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7, r_p8, r_p9, r_p10;
    t_pipe n_p1, n_p2, n_p3, n_p4, n_p5, n_p6, n_p8, n_p9, n_p10, n_dv0;
    t_pipe r_dv [0:DIV_ST];
    t_pipe n_dv [0:DIV_ST-1];
    t_pipe r_pe, r_pm, n_pe, n_pm;
    logic [63:0]        r_srd, r_ard;
    logic signed [23:0] r_out, n_out;

    assign adv     = !(r_vld[NV-1] && i_stall);
    assign o_stall = r_vld[NV-1] && i_stall;
    assign in_xfer = i_valid && !o_stall;
    assign o_valid = r_vld[NV-1];
    assign o_sample_out = r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grit <= '0;
            r_char <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_GRIT_AMOUNT:   r_grit <= (i_cfg_data > Q16_ONE) ? Q16_ONE : i_cfg_data;
                CFG_CHARACTER_MIX: r_char <= (i_cfg_data > Q16_ONE) ? Q16_ONE : i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NV-2:0], in_xfer};
        end
    end

    // wet = grit*env, sample magnitude, clamped |x|
    always_comb begin
        logic [16:0] env;
        logic [23:0] smag;
        n_p1 = '0;
        env  = (i_envelope_gain > Q16_ONE) ? Q16_ONE : i_envelope_gain;
        n_p1.wet  = 33'(r_grit * env);
        n_p1.glow = r_grit < GRIT_FLOOR;
        n_p1.s    = i_sample_in;
        n_p1.neg  = i_sample_in[23];
        smag      = i_sample_in[23] ? 24'(-i_sample_in) : 24'(i_sample_in);
        n_p1.xm   = XW'(smag) << SH;
        n_p1.xc   = (64'(n_p1.xm) > 64'(BEND_CLAMP)) ? BEND_CLAMP : 32'(n_p1.xm);
    end

    // bypass flag, drive and x^2
    always_comb begin
        logic [36:0] w9;
        logic [63:0] sq_full;
        n_p2     = r_p1;
        n_p2.byp = r_p1.glow || (r_p1.wet == '0);
        w9       = {r_p1.wet, 3'b000} + 37'(r_p1.wet);
        n_p2.d16 = 20'(21'(Q16_ONE) + 21'((w9 + 37'd32768) >> 16));
        sq_full  = r_p1.xc * r_p1.xc;
        n_p2.sq  = 34'((sq_full + (64'd1 << 29)) >> 30);
    end

    always_comb begin
        logic [48:0] bp;
        n_p3      = r_p2;
        bp        = r_p2.sq * K_BEND;
        n_p3.bend = 33'(33'(r_p2.xc) + 33'((bp + 49'd32768) >> 16));
    end

    // scale both curve arguments by drive
    always_comb begin
        logic [XW+19:0] sp;
        logic [52:0]    ap;
        n_p4      = r_p3;
        sp        = r_p3.xm * r_p3.d16;
        n_p4.sarg = AW'((sp + (XW + 20)'(32768)) >> 16);
        ap        = r_p3.bend * r_p3.d16;
        n_p4.a1   = 37'((ap + 53'd32768) >> 16);
    end

    always_comb begin
        logic [53:0] kp;
        n_p5      = r_p4;
        kp        = r_p4.a1 * K_ASYM;
        n_p5.aarg = AW'((kp + 54'd32768) >> 16);
    end

    // table position; arguments at 8.0 and above take the last entry
    always_comb begin
        logic [33+IW:0] spos;
        logic [33+IW:0] apos;
        n_p6       = r_p5;
        n_p6.ssat  = |r_p5.sarg[AW-1:33];
        n_p6.asat  = |r_p5.aarg[AW-1:33];
        spos       = r_p5.sarg[32:0] * DEPTH_K;
        apos       = r_p5.aarg[32:0] * DEPTH_K;
        n_p6.sidx  = IW'(spos >> 33);
        n_p6.aidx  = IW'(apos >> 33);
        n_p6.sfrac = spos[32:3];
        n_p6.afrac = apos[32:3];
    end

    // interpolation products
    always_comb begin
        logic signed [32:0] sd;
        logic signed [32:0] ad;
        n_p8       = r_p7;
        n_p8.st0   = r_srd[31:0];
        n_p8.at0   = r_ard[31:0];
        sd         = $signed({1'b0, r_srd[63:32]}) - $signed({1'b0, r_srd[31:0]});
        ad         = $signed({1'b0, r_ard[63:32]}) - $signed({1'b0, r_ard[31:0]});
        n_p8.sprod = sd * $signed({1'b0, r_p7.sfrac});
        n_p8.aprod = ad * $signed({1'b0, r_p7.afrac});
    end

    always_comb begin
        logic signed [31:0] sv;
        logic signed [31:0] av;
        n_p9 = r_p8;
        sv   = r_p8.ssat ? $signed(TANH_LAST_HALF) :
               32'(f_rsr($signed(80'(r_p8.st0)) + f_rsr(80'(r_p8.sprod), 30), 1));
        av   = r_p8.asat ? $signed(TANH_LAST_HALF) :
               32'(f_rsr($signed(80'(r_p8.at0)) + f_rsr(80'(r_p8.aprod), 30), 1));
        n_p9.sym  = r_p8.neg ? -sv : sv;
        n_p9.asym = r_p8.neg ? -av : av;
    end

    always_comb begin
        logic signed [32:0] bd;
        n_p10      = r_p9;
        bd         = 33'(r_p9.asym) - 33'(r_p9.sym);
        n_p10.bprod = $signed({1'b0, r_char}) * bd;
    end

    // blend, then set up |blend|*2^16 + d/2 for the rounded division
    always_comb begin
        logic signed [32:0] blend;
        logic [32:0]        bmag;
        n_dv0       = r_p10;
        blend       = 33'(r_p10.sym) + 33'(f_rsr(80'(r_p10.bprod), 16));
        n_dv0.bneg  = blend[32];
        bmag        = blend[32] ? 33'(-blend) : 33'(blend);
        n_dv0.num   = 48'({bmag, 16'b0}) + 48'(r_p10.d16 >> 1);
        n_dv0.rem   = 20'(n_dv0.num >> DIV_QBITS);
        n_dv0.quo   = '0;
    end

    for (genvar k = 0; k < DIV_ST; k++) begin : g_div
        always_comb begin
            logic [20:0] trial;
            n_dv[k] = r_dv[k];
            for (int j = 0; j < DIV_STEP; j++) begin
                trial = {n_dv[k].rem, n_dv[k].num[DIV_QBITS-1-DIV_STEP*k-j]};
                if (trial >= {1'b0, n_dv[k].d16}) begin
                    n_dv[k].rem = 20'(trial - {1'b0, n_dv[k].d16});
                    n_dv[k].quo[DIV_QBITS-1-DIV_STEP*k-j] = 1'b1;
                end else begin
                    n_dv[k].rem = trial[19:0];
                end
            end
        end
    end

    // shaped - x, then wet mix
    always_comb begin
        logic signed [32:0]   shaped;
        logic signed [XW-1:0] x30;
        n_pe    = r_dv[DIV_ST];
        shaped  = r_dv[DIV_ST].bneg ? -$signed({1'b0, r_dv[DIV_ST].quo}) :
                                      $signed({1'b0, r_dv[DIV_ST].quo});
        x30     = XW'(r_dv[DIV_ST].s) <<< SH;
        n_pe.diff = DW'(shaped) - DW'(x30);
    end

    always_comb begin
        n_pm       = r_pe;
        n_pm.mprod = $signed({1'b0, r_pe.wet[32:8]}) * r_pe.diff;
    end

    always_comb begin
        logic signed [XW-1:0] x30;
        logic signed [79:0]   mix;
        logic signed [79:0]   r;
        x30 = XW'(r_pm.s) <<< SH;
        mix = 80'(x30) + f_rsr(80'(r_pm.mprod), 24);
        r   = f_rsr(mix, SH);
        if (r > 80'(SAMPLE_MAX)) begin
            n_out = SAMPLE_MAX;
        end else if (r < 80'(SAMPLE_MIN)) begin
            n_out = SAMPLE_MIN;
        end else begin
            n_out = r[23:0];
        end
        if (r_pm.byp) begin
            n_out = r_pm.s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_p3  <= n_p3;
            r_p4  <= n_p4;
            r_p5  <= n_p5;
            r_p6  <= n_p6;
            r_p7  <= r_p6;
            r_srd <= TANH_PAIR[r_p6.sidx];
            r_ard <= TANH_PAIR[r_p6.aidx];
            r_p8  <= n_p8;
            r_p9  <= n_p9;
            r_p10 <= n_p10;
            r_dv[0] <= n_dv0;
            for (int k = 0; k < DIV_ST; k++) begin
                r_dv[k+1] <= n_dv[k];
            end
            r_pe  <= n_pe;
            r_pm  <= n_pm;
            r_out <= n_out;
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Scoreboard for the waveshaper: computes the expected shaped sample for each
// accepted input and checks outputs in order.
class shaper_scoreboard;
    longint unsigned tanh_points[];
    logic [16:0] grit;
    logic [16:0] character;
    logic signed [23:0] pending[$];
    int mismatches;
    int checked;
    int depth;
    int frac_bits;

    function new(int table_depth, int sample_frac);
        longint unsigned den, a, a3, t, d;
        depth = table_depth;
        frac_bits = sample_frac;
        tanh_points = new[table_depth + 1];
        for (int i = 0; i <= table_depth; i++) begin
            den = longint'(table_depth) << 10;
            a = ((longint'(i) << 34) + den / 2) / den;
            a3 = (((a * a) >> 31) * a) >> 31;
            t = a - a3 / 3;
            for (int k = 0; k < 10; k++) begin
                d = (64'd1 << 31) + ((t * t + (64'd1 << 30)) >> 31);
                t = (((t << 1) << 31) + d / 2) / d;
                if (t > (64'd1 << 31))
                    t = 64'd1 << 31;
            end
            tanh_points[i] = t;
        end
        grit = 0;
        character = 0;
        mismatches = 0;
        checked = 0;
    endfunction

    static function longint round_shift(longint v, int n);
        longint unsigned half, mag;
        half = (n != 0) ? (64'd1 << (n - 1)) : 0;
        if (v < 0) begin
            mag = -v;
            return -longint'((mag + half) >> n);
        end
        return longint'((longint'(unsigned'(v)) + half) >> n);
    endfunction

    function longint tanh_q30(longint unsigned m);
        longint unsigned pos, idx;
        longint frac, t0, t1;
        if (m >= (64'd8 << 30))
            return round_shift(tanh_points[depth], 1);
        pos = m * longint'(depth);
        idx = pos >> 33;
        frac = (pos >> 3) & ((64'd1 << 30) - 1);
        if (idx >= depth)
            return round_shift(tanh_points[depth], 1);
        t0 = tanh_points[idx];
        t1 = tanh_points[idx + 1];
        return round_shift(t0 + round_shift((t1 - t0) * frac, 30), 1);
    endfunction

    function void write_register(logic index, logic [16:0] value);
        logic [16:0] v;
        v = (value > 17'd65536) ? 17'd65536 : value;
        if (index == tbw_pkg::CFG_GRIT_AMOUNT)
            grit = v;
        else
            character = v;
    endfunction

    function void note_transfer(logic signed [23:0] smp, logic [16:0] env_in);
        longint unsigned env, wet32, d16, xm, sym_arg, xc, sq, bend, a1, asym_arg, dm, q;
        longint x30, sym, asym, blend, shaped, wet24, mix, r;
        bit neg;
        env = (env_in > 17'd65536) ? 65536 : env_in;
        wet32 = longint'(grit) * env;
        if (grit < tbw_pkg::GRIT_FLOOR || wet32 == 0) begin
            pending.push_back(smp);
            return;
        end
        d16 = 65536 + ((9 * wet32 + 32768) >> 16);
        x30 = longint'(smp) * (longint'(1) << (30 - frac_bits));
        neg = x30 < 0;
        xm = neg ? -x30 : x30;
        sym_arg = round_shift(longint'(xm * d16), 16);
        sym = tanh_q30(sym_arg);
        xc = (xm > 64'd3758096384) ? 64'd3758096384 : xm;
        sq = (xc * xc + (64'd1 << 29)) >> 30;
        bend = xc + round_shift(longint'(sq * 22938), 16);
        a1 = round_shift(longint'(bend * d16), 16);
        asym_arg = round_shift(longint'(a1 * 85197), 16);
        asym = tanh_q30(asym_arg);
        if (neg) begin
            sym = -sym;
            asym = -asym;
        end
        blend = sym + round_shift(longint'(character) * (asym - sym), 16);
        dm = (blend < 0) ? -(blend * 65536) : blend * 65536;
        q = (dm + d16 / 2) / d16;
        shaped = (blend < 0) ? -longint'(q) : longint'(q);
        wet24 = wet32 >> 8;
        mix = x30 + round_shift(wet24 * (shaped - x30), 24);
        r = round_shift(mix, 30 - frac_bits);
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        pending.push_back(r[23:0]);
    endfunction

    function void check_result(logic signed [23:0] got);
        logic signed [23:0] want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output sample %0d", got);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("sample_out mismatch: expected %0d, got %0d", want, got);
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tbw_pkg::*;

    localparam int LATENCY = 14 + DIV_QBITS / DIV_STEP;
    localparam longint CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [23:0] sample_drv;
    logic [16:0]        env_drv;
    logic               out_valid;
    logic               out_stall;
    logic signed [23:0] sample_res;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [16:0]        cfg_data;

    shaper_scoreboard sb;
    longint cycles;
    bit hold_request;
    int sent;

    tanh_blend_waveshaper u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_sample_in(sample_drv), .i_envelope_gain(env_drv),
        .o_valid(out_valid), .i_stall(out_stall), .o_sample_out(sample_res),
        .i_cfg_wr_en(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tanh_blend_waveshaper verification failed");
            $finish;
        end
    end

    // input transfers feed the predictor, output transfers are checked
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            sb.note_transfer(sample_drv, env_drv);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(sample_res);
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver side: random stalls, plus one long hold-off on request
    initial begin
        int g;
        out_stall = 1;
        @(negedge clk);
        while (!rst_n)
            @(negedge clk);
        forever begin
            if (hold_request) begin
                out_stall <= 1;
                repeat (300) @(negedge clk);
                hold_request = 0;
            end
            g = gap_length();
            if (g > 0) begin
                out_stall <= 1;
                repeat (g) @(negedge clk);
            end
            out_stall <= 0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    end

    task automatic send_sample(logic signed [23:0] s, logic [16:0] e, bit idle);
        int g;
        in_valid <= 1;
        sample_drv <= s;
        env_drv <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
        g = idle ? gap_length() : 0;
        if (g > 0) begin
            in_valid <= 0;
            sample_drv <= 24'($urandom);
            env_drv <= 17'($urandom);
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic set_register(logic idx, logic [16:0] value);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 0;
        sb.write_register(idx, value);
        @(negedge clk);
    endtask

    function automatic logic [16:0] random_q16();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 17'd0;
        if (r == 1)
            return 17'd65536;
        if (r == 2)
            return 17'($urandom_range(65537, 131071));
        if (r == 3)
            return 17'($urandom_range(0, 10));
        return 17'($urandom_range(0, 65536));
    endfunction

    function automatic logic signed [23:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 24'($signed($urandom_range(0, 2097152)) - 1048576);
        if (r < 6)
            return 24'($signed($urandom_range(0, 262144)) - 131072);
        if (r == 6)
            return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        return 24'($urandom);
    endfunction

    initial begin
        logic signed [23:0] edge_samples[8];
        logic [16:0] edge_envs[4];
        logic [16:0] grit_set[6];
        logic [16:0] char_set[6];
        sb = new(1024, 20);
        cycles = 0;
        hold_request = 0;
        sent = 0;
        rst_n = 0;
        in_valid = 0;
        sample_drv = 0;
        env_drv = 0;
        cfg_we = 0;
        cfg_index = CFG_GRIT_AMOUNT;
        cfg_data = 0;
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // reset defaults: grit zero, every sample bypasses
        send_sample(24'sh123456, 17'd65536, 0);
        drain();

        edge_samples = '{SAMPLE_MAX, SAMPLE_MIN, 24'sd0, 24'sd1, -24'sd1,
                         24'sd1048576, -24'sd1048576, 24'sd3670016};
        edge_envs = '{17'd65536, 17'h1FFFF, 17'd0, 17'd32768};
        set_register(CFG_GRIT_AMOUNT, 17'd65536);
        set_register(CFG_CHARACTER_MIX, 17'h1FFFF);
        foreach (edge_samples[i])
            send_sample(edge_samples[i], edge_envs[i % 4], 0);
        drain();
        // grit just under and at the floor
        set_register(CFG_GRIT_AMOUNT, 17'd6);
        set_register(CFG_CHARACTER_MIX, 17'd0);
        send_sample(24'sd500000, 17'd65536, 0);
        send_sample(-24'sd500000, 17'd65536, 0);
        drain();
        set_register(CFG_GRIT_AMOUNT, 17'd7);
        send_sample(24'sd500000, 17'd65536, 0);
        send_sample(SAMPLE_MIN, 17'd1, 0);
        drain();
        set_register(CFG_GRIT_AMOUNT, 17'h1FFFF);
        set_register(CFG_CHARACTER_MIX, 17'd32768);
        foreach (edge_samples[i])
            send_sample(edge_samples[i], 17'd65536, 0);
        drain();

        grit_set = '{17'd65536, 17'd0, 17'd7, 17'd40000, 17'h1FFFF, 17'd20000};
        char_set = '{17'd0, 17'd65536, 17'd12345, 17'h10001, 17'd50000, 17'd65536};
        for (int phase = 0; phase < 6; phase++) begin
            set_register(CFG_GRIT_AMOUNT, grit_set[phase]);
            set_register(CFG_CHARACTER_MIX, char_set[phase]);
            for (int n = 0; n < 70; n++) begin
                if (phase == 2 && n == 10)
                    hold_request = 1;
                send_sample(random_sample(), random_q16(), 1);
            end
            drain();
        end
        for (int phase = 0; phase < 6; phase++) begin
            set_register(CFG_GRIT_AMOUNT, random_q16());
            set_register(CFG_CHARACTER_MIX, random_q16());
            for (int n = 0; n < 70; n++)
                send_sample(random_sample(), random_q16(), n > 35);
            drain();
        end

        $display("%0d samples sent, %0d results checked across 17 register settings",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tanh_blend_waveshaper verification clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("tanh_blend_waveshaper verification failed");
        end
        $finish;
    end
endmodule
